/* design/gdp_pkg.sv */
package gdp_pkg;

    localparam int TILE_SIZE_DEF = 128;

    localparam int COORD_W     = 7;
    localparam int COLOR_W     = 16;
    localparam int INDEX_W     = 14;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int DSEL_W      = 2;
    localparam int DITHER_W    = 3;
    localparam int DIFF_W      = CHAN_W + 1;
    localparam int PROD_W      = 15;
    localparam int QUOT_W      = 15;
    localparam int RECIP_W     = 17;
    localparam int SUM_W       = 18;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_COLOR   = 1'b1;

    localparam logic [DSEL_W-1:0] DSEL_EVEN_EVEN = 2'd0;
    localparam logic [DSEL_W-1:0] DSEL_EVEN_ODD  = 2'd1;
    localparam logic [DSEL_W-1:0] DSEL_ODD_EVEN  = 2'd2;
    localparam logic [DSEL_W-1:0] DSEL_ODD_ODD   = 2'd3;

    localparam logic signed [SUM_W-1:0] CHAN_MAX = 18'sd255;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_rgb8;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [DSEL_W-1:0]  dsel;
        logic [INDEX_W-1:0] index;
    } t_item;

    // channel 0 red, 1 green, 2 blue, all left aligned to 8 bits
    function automatic t_rgb8 widen(input logic [COLOR_W-1:0] c);
        t_rgb8 ch;
        ch[0] = {c[15:11], 3'b000};
        ch[1] = {c[10:5], 2'b00};
        ch[2] = {c[4:0], 3'b000};
        return ch;
    endfunction

    function automatic logic [COLOR_W-1:0] pack565(input t_rgb8 ch);
        return {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
    endfunction

    function automatic logic signed [DITHER_W-1:0] dither(input logic [DSEL_W-1:0] sel);
        logic signed [DITHER_W-1:0] d;
        case (sel)
            DSEL_EVEN_EVEN: d = -3'sd2;
            DSEL_EVEN_ODD:  d = 3'sd1;
            DSEL_ODD_EVEN:  d = 3'sd2;
            DSEL_ODD_ODD:   d = -3'sd1;
            default:        d = 3'sd0;
        endcase
        return d;
    endfunction

endpackage

/* design/gdp_front.sv */
module gdp_front #(
    parameter int TILE_SIZE = gdp_pkg::TILE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gdp_pkg::COLOR_W-1:0]    i_cfg_data,
    input  logic [gdp_pkg::COORD_W-1:0]    i_col,
    input  logic [gdp_pkg::COORD_W-1:0]    i_row,
    output gdp_pkg::t_item                 o_item,
    output logic [gdp_pkg::COLOR_W-1:0]    o_start_color,
    output logic [gdp_pkg::COLOR_W-1:0]    o_end_color
);

    logic [gdp_pkg::COLOR_W-1:0] r_start_color;
    logic [gdp_pkg::COLOR_W-1:0] r_end_color;
    logic [31:0]                 w_index_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color <= '0;
            r_end_color   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gdp_pkg::CFG_START_COLOR: r_start_color <= i_cfg_data;
                gdp_pkg::CFG_END_COLOR:   r_end_color   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // linear index wraps to the output width
    assign w_index_full = 32'(i_row) * 32'(TILE_SIZE) + 32'(i_col);

    always_comb begin
        o_item.row   = i_row;
        o_item.dsel  = {i_row[0], i_col[0]};
        o_item.index = w_index_full[gdp_pkg::INDEX_W-1:0];
    end

    assign o_start_color = r_start_color;
    assign o_end_color   = r_end_color;

endmodule

/* design/gdp_queue.sv */
module gdp_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  gdp_pkg::t_item               i_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output gdp_pkg::t_item               o_item,
    output logic [gdp_pkg::QCNT_W-1:0]   o_count
);

    gdp_pkg::t_item                  r_mem [gdp_pkg::QUEUE_DEPTH];
    logic [gdp_pkg::QPTR_W-1:0]      r_wptr;
    logic [gdp_pkg::QPTR_W-1:0]      r_rptr;
    logic [gdp_pkg::QCNT_W-1:0]      r_count;
    logic                            w_full;
    logic                            w_push;
    logic                            w_pop;

    assign w_full = (r_count == gdp_pkg::QCNT_W'(gdp_pkg::QUEUE_DEPTH));
    assign w_push = i_valid && !w_full;
    assign w_pop  = (r_count != '0) && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == gdp_pkg::QPTR_W'(gdp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == gdp_pkg::QPTR_W'(gdp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_stall = w_full;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

/* design/gdp_back.sv */
module gdp_back #(
    parameter int TILE_SIZE = gdp_pkg::TILE_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [gdp_pkg::COLOR_W-1:0]  i_start_color,
    input  logic [gdp_pkg::COLOR_W-1:0]  i_end_color,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  gdp_pkg::t_item               i_item,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [gdp_pkg::COLOR_W-1:0]  o_pixel,
    output logic [gdp_pkg::INDEX_W-1:0]  o_pixel_index
);

    localparam int DEN     = TILE_SIZE - 1;
    localparam int DEN_LOG = $clog2(DEN);
    localparam int SHIFT   = gdp_pkg::PROD_W + DEN_LOG;
    localparam int RECIP_I = ((1 << SHIFT) + DEN - 1) / DEN;
    localparam logic [gdp_pkg::RECIP_W-1:0] RECIP = gdp_pkg::RECIP_W'(RECIP_I);
    localparam int SCALED_W = gdp_pkg::PROD_W + gdp_pkg::RECIP_W;

    gdp_pkg::t_rgb8 w_start_ch;
    gdp_pkg::t_rgb8 w_end_ch;

    // stage 1: |end - start| * row
    logic signed [gdp_pkg::DIFF_W-1:0] w_diff [gdp_pkg::NUM_CHAN];
    logic [gdp_pkg::CHAN_W-1:0]        w_mag  [gdp_pkg::NUM_CHAN];
    logic [gdp_pkg::NUM_CHAN-1:0]      w_neg;
    logic [gdp_pkg::PROD_W-1:0]        w_prod [gdp_pkg::NUM_CHAN];

    logic                              r_s1_valid;
    logic [gdp_pkg::PROD_W-1:0]        r_s1_prod [gdp_pkg::NUM_CHAN];
    logic [gdp_pkg::NUM_CHAN-1:0]      r_s1_neg;
    logic [gdp_pkg::DSEL_W-1:0]        r_s1_dsel;
    logic [gdp_pkg::INDEX_W-1:0]       r_s1_index;

    // stage 2: quotient by reciprocal multiply
    logic [SCALED_W-1:0]               w_scaled [gdp_pkg::NUM_CHAN];
    logic [gdp_pkg::QUOT_W-1:0]        w_quot   [gdp_pkg::NUM_CHAN];

    logic                              r_s2_valid;
    logic [gdp_pkg::QUOT_W-1:0]        r_s2_quot [gdp_pkg::NUM_CHAN];
    logic [gdp_pkg::NUM_CHAN-1:0]      r_s2_neg;
    logic [gdp_pkg::DSEL_W-1:0]        r_s2_dsel;
    logic [gdp_pkg::INDEX_W-1:0]       r_s2_index;

    // stage 3: add start and dither, clamp, pack
    logic signed [gdp_pkg::DITHER_W-1:0] w_dither;
    logic signed [gdp_pkg::SUM_W-1:0]    w_qs  [gdp_pkg::NUM_CHAN];
    logic signed [gdp_pkg::SUM_W-1:0]    w_sum [gdp_pkg::NUM_CHAN];
    gdp_pkg::t_rgb8                      w_clamped;

    logic                              r_o_valid;
    logic [gdp_pkg::COLOR_W-1:0]       r_o_pixel;
    logic [gdp_pkg::INDEX_W-1:0]       r_o_index;

    logic w_adv_out;
    logic w_adv_s2;
    logic w_adv_s1;

    assign w_start_ch = gdp_pkg::widen(i_start_color);
    assign w_end_ch   = gdp_pkg::widen(i_end_color);

    assign w_adv_out = !r_o_valid || !i_stall;
    assign w_adv_s2  = !r_s2_valid || w_adv_out;
    assign w_adv_s1  = !r_s1_valid || w_adv_s2;
    assign o_ready   = w_adv_s1;

    always_comb begin
        for (int k = 0; k < gdp_pkg::NUM_CHAN; k++) begin
            w_diff[k] = $signed({1'b0, w_end_ch[k]}) - $signed({1'b0, w_start_ch[k]});
            w_neg[k]  = w_diff[k][gdp_pkg::DIFF_W-1];
            w_mag[k]  = w_neg[k] ? gdp_pkg::CHAN_W'(-w_diff[k])
                                 : w_diff[k][gdp_pkg::CHAN_W-1:0];
            w_prod[k] = gdp_pkg::PROD_W'(w_mag[k]) * gdp_pkg::PROD_W'(i_item.row);
        end
    end

    // exact floor division for any numerator below 2**PROD_W
    always_comb begin
        for (int k = 0; k < gdp_pkg::NUM_CHAN; k++) begin
            w_scaled[k] = SCALED_W'(r_s1_prod[k]) * SCALED_W'(RECIP);
            w_quot[k]   = gdp_pkg::QUOT_W'(w_scaled[k] >> SHIFT);
        end
    end

    always_comb begin
        w_dither = gdp_pkg::dither(r_s2_dsel);
        for (int k = 0; k < gdp_pkg::NUM_CHAN; k++) begin
            // truncation toward zero: negate the magnitude quotient
            w_qs[k]  = r_s2_neg[k]
                       ? -$signed({{(gdp_pkg::SUM_W - gdp_pkg::QUOT_W){1'b0}}, r_s2_quot[k]})
                       :  $signed({{(gdp_pkg::SUM_W - gdp_pkg::QUOT_W){1'b0}}, r_s2_quot[k]});
            w_sum[k] = $signed({{(gdp_pkg::SUM_W - gdp_pkg::CHAN_W){1'b0}}, w_start_ch[k]})
                       + w_qs[k]
                       + $signed({{(gdp_pkg::SUM_W - gdp_pkg::DITHER_W){w_dither[2]}},
                                  w_dither});
            if (w_sum[k] < 0) begin
                w_clamped[k] = '0;
            end else if (w_sum[k] > gdp_pkg::CHAN_MAX) begin
                w_clamped[k] = '1;
            end else begin
                w_clamped[k] = w_sum[k][gdp_pkg::CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_adv_s1) begin
                r_s1_valid <= i_valid;
            end
            if (w_adv_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_adv_out) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_s1) begin
            for (int k = 0; k < gdp_pkg::NUM_CHAN; k++) begin
                r_s1_prod[k] <= w_prod[k];
            end
            r_s1_neg   <= w_neg;
            r_s1_dsel  <= i_item.dsel;
            r_s1_index <= i_item.index;
        end
        if (w_adv_s2) begin
            for (int k = 0; k < gdp_pkg::NUM_CHAN; k++) begin
                r_s2_quot[k] <= w_quot[k];
            end
            r_s2_neg   <= r_s1_neg;
            r_s2_dsel  <= r_s1_dsel;
            r_s2_index <= r_s1_index;
        end
        if (w_adv_out) begin
            r_o_pixel <= gdp_pkg::pack565(w_clamped);
            r_o_index <= r_s2_index;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel       = r_o_pixel;
    assign o_pixel_index = r_o_index;

endmodule

/* design/gradient_dither_pixel.sv */
// Vertical RGB565 gradient generator with 2x2 ordered dither. Each accepted (col, row)
// transaction yields one pixel blending start_color (row 0) into end_color
// (row TILE_SIZE-1), plus the linear index row*TILE_SIZE+col (low 14 bits). One
// transaction is taken per clock while o_stall is low. Each accepted transaction passes
// through the input queue, the multiply stage and the reciprocal-divide stage, after
// which the clamp/pack output register presents it.
// The input queue holds two transactions, so o_stall rises only after the output has been
// stalled for a while.
// Write start_color (index 0) and end_color (index 1) only while no transaction is in flight.
module gradient_dither_pixel #(
    parameter int TILE_SIZE = gdp_pkg::TILE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gdp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gdp_pkg::COLOR_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [gdp_pkg::COORD_W-1:0]   i_col,
    input  logic [gdp_pkg::COORD_W-1:0]   i_row,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gdp_pkg::COLOR_W-1:0]   o_pixel,
    output logic [gdp_pkg::INDEX_W-1:0]   o_pixel_index
);

    gdp_pkg::t_item                w_front_item;
    gdp_pkg::t_item                w_q_item;
    logic                          w_q_valid;
    logic                          w_back_ready;
    logic [gdp_pkg::QCNT_W-1:0]    w_q_count;
    logic [gdp_pkg::COLOR_W-1:0]   w_start_color;
    logic [gdp_pkg::COLOR_W-1:0]   w_end_color;

    gdp_front #(
        .TILE_SIZE(TILE_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_col        (i_col),
        .i_row        (i_row),
        .o_item       (w_front_item),
        .o_start_color(w_start_color),
        .o_end_color  (w_end_color)
    );

    gdp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (w_front_item),
        .o_valid(w_q_valid),
        .i_ready(w_back_ready),
        .o_item (w_q_item),
        .o_count(w_q_count)
    );

    gdp_back #(
        .TILE_SIZE(TILE_SIZE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_color(w_start_color),
        .i_end_color  (w_end_color),
        .i_valid      (w_q_valid),
        .o_ready      (w_back_ready),
        .i_item       (w_q_item),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel      (o_pixel),
        .o_pixel_index(o_pixel_index)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && (w_q_count == '0)))
        else $error("pipeline or queue not empty after reset");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= gdp_pkg::QCNT_W'(gdp_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (w_q_count == '0)) |=> (w_q_count != '0))
        else $error("accepted transaction lost in queue");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_count == '0) |-> !w_q_valid)
        else $error("queue offers data while empty");

endmodule

/* dv/tb_top.sv */
module tb_top;

    localparam int TILE       = gdp_pkg::TILE_SIZE_DEF;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [gdp_pkg::COLOR_W-1:0] pixel;
        logic [gdp_pkg::INDEX_W-1:0] index;
    } t_pixel;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [gdp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [gdp_pkg::COLOR_W-1:0]   i_cfg_data;
    logic                          i_valid;
    logic                          o_stall;
    logic [gdp_pkg::COORD_W-1:0]   i_col;
    logic [gdp_pkg::COORD_W-1:0]   i_row;
    logic                          o_valid;
    logic                          i_stall;
    logic [gdp_pkg::COLOR_W-1:0]   o_pixel;
    logic [gdp_pkg::INDEX_W-1:0]   o_pixel_index;

    // gradient endpoints as the block should hold them
    logic [gdp_pkg::COLOR_W-1:0] top_color;
    logic [gdp_pkg::COLOR_W-1:0] bottom_color;

    t_pixel pixel_due[$];
    int     err_count;
    int     cycle_count;
    bit     tx_jitter;
    bit     rx_jitter;
    int     hold_request;

    gradient_dither_pixel uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_col         (i_col),
        .i_row         (i_row),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel       (o_pixel),
        .o_pixel_index (o_pixel_index)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pixel_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_pixel gradient_pixel(input logic [gdp_pkg::COORD_W-1:0] c,
                                              input logic [gdp_pkg::COORD_W-1:0] r);
        int                         top[3];
        int                         bot[3];
        int                         level;
        int                         dith;
        logic [gdp_pkg::CHAN_W-1:0] q[3];
        logic [31:0]                lin;
        t_pixel                     res;
        top[0] = int'({top_color[15:11], 3'b000});
        top[1] = int'({top_color[10:5], 2'b00});
        top[2] = int'({top_color[4:0], 3'b000});
        bot[0] = int'({bottom_color[15:11], 3'b000});
        bot[1] = int'({bottom_color[10:5], 2'b00});
        bot[2] = int'({bottom_color[4:0], 3'b000});
        case ({r[0], c[0]})
            gdp_pkg::DSEL_EVEN_EVEN: dith = -2;
            gdp_pkg::DSEL_EVEN_ODD:  dith = 1;
            gdp_pkg::DSEL_ODD_EVEN:  dith = 2;
            gdp_pkg::DSEL_ODD_ODD:   dith = -1;
            default:                 dith = 0;
        endcase
        for (int k = 0; k < 3; k++) begin
            // int division truncates toward zero, as the descending ramp needs
            level = top[k] + ((bot[k] - top[k]) * int'(r)) / (TILE - 1) + dith;
            if (level < 0)
                q[k] = 8'd0;
            else if (level > 255)
                q[k] = 8'd255;
            else
                q[k] = level[7:0];
        end
        res.pixel = {q[0][7:3], q[1][7:2], q[2][7:3]};
        lin = int'(r) * TILE + int'(c);
        res.index = lin[gdp_pkg::INDEX_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
                 cycle_count, what, got, want);
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_due.size() == 0) begin
                report_mismatch("transaction with nothing expected", 32'(o_pixel), '0);
            end else begin
                want = pixel_due.pop_front();
                if (o_pixel !== want.pixel)
                    report_mismatch("pixel", 32'(o_pixel), 32'(want.pixel));
                if (o_pixel_index !== want.index)
                    report_mismatch("pixel_index", 32'(o_pixel_index), 32'(want.index));
            end
        end
    end

    // output side: random stall bursts, or one long hold-off on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && rx_jitter && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // entered and left just after a falling edge; valid stays up for a follow-on item
    task automatic send_coord(input logic [gdp_pkg::COORD_W-1:0] c,
                              input logic [gdp_pkg::COORD_W-1:0] r);
        int gap;
        gap = (tx_jitter && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_col = c;
        i_row = r;
        do @(posedge i_clk); while (o_stall);
        pixel_due.push_back(gradient_pixel(c, r));
        @(negedge i_clk);
    endtask

    task automatic wait_for_pixels();
        i_valid = 1'b0;
        wait (pixel_due.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_colors(input logic [gdp_pkg::COLOR_W-1:0] top,
                                input logic [gdp_pkg::COLOR_W-1:0] bot);
        wait_for_pixels();
        i_cfg_we = 1'b1;
        i_cfg_idx = gdp_pkg::CFG_START_COLOR;
        i_cfg_data = top;
        @(negedge i_clk);
        i_cfg_idx = gdp_pkg::CFG_END_COLOR;
        i_cfg_data = bot;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        top_color = top;
        bottom_color = bot;
    endtask

    task automatic send_corners();
        send_coord(7'd0, 7'd0);
        send_coord(7'd1, 7'd0);
        send_coord(7'd126, 7'd1);
        send_coord(7'd127, 7'd127);
        send_coord(7'd0, 7'd126);
        send_coord(7'd127, 7'd63);
    endtask

    task automatic test_reset_state();
        send_coord(7'd0, 7'd0);
        send_coord(7'd1, 7'd0);
        send_coord(7'd0, 7'd1);
        send_coord(7'd127, 7'd127);
        wait_for_pixels();
    endtask

    task automatic test_corner_pixels();
        write_colors(16'hFFFF, 16'h0000);
        send_corners();
        write_colors(16'h0000, 16'hFFFF);
        send_corners();
        // channels ramp in opposite directions
        write_colors(16'hF800, 16'h07FF);
        send_corners();
        wait_for_pixels();
    endtask

    task automatic test_random_gradients();
        logic [gdp_pkg::COLOR_W-1:0] top;
        logic [gdp_pkg::COLOR_W-1:0] bot;
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        for (int p = 0; p < 6; p++) begin
            top = 16'($urandom_range(0, 65535));
            bot = 16'($urandom_range(0, 65535));
            if (p == 1) top = 16'h0000;
            if (p == 2) bot = 16'hFFFF;
            if (p == 3) top = bot;
            write_colors(top, bot);
            for (int n = 0; n < 220; n++) begin
                // stretches with no input idling
                tx_jitter = (n < 60) || (n >= 120);
                send_coord(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            end
        end
        wait_for_pixels();
    endtask

    task automatic test_full_queue();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        write_colors(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        hold_request = 80;
        for (int n = 0; n < 30; n++)
            send_coord(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        wait_for_pixels();
    endtask

    task automatic test_pause_and_resume();
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        for (int n = 0; n < 20; n++)
            send_coord(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        wait_for_pixels();
        for (int n = 0; n < 20; n++)
            send_coord(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        wait_for_pixels();
    endtask

    task automatic test_streaming();
        logic [gdp_pkg::COORD_W-1:0] c;
        logic [gdp_pkg::COORD_W-1:0] r;
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        write_colors(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        c = 7'($urandom_range(0, 127));
        r = 7'($urandom_range(0, 127));
        // raster order at full rate
        for (int n = 0; n < 300; n++) begin
            send_coord(c, r);
            c++;
            if (c == 0) r++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = gdp_pkg::CFG_START_COLOR;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_col = '0;
        i_row = '0;
        top_color = '0;
        bottom_color = '0;
        err_count = 0;
        cycle_count = 0;
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        hold_request = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_corner_pixels();
        test_random_gradients();
        test_full_queue();
        test_pause_and_resume();
        test_streaming();

        wait_for_pixels();
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
